/* sv/lcsat_pkg.sv */
package lcsat_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int OFFSET_W   = 25;
	localparam int COUNT_W    = 8;
	localparam int GAIN_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int CORR_W     = 27;
	localparam int SUM_W      = 36;
	localparam int UNITS_W    = CORR_W + GAIN_W - FRAC_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int DIV_STEPS = SUM_W;
	localparam int MUL_STEPS = GAIN_W;

	localparam logic [COUNT_W-1:0] TARE_COUNT    = 8'd64;
	localparam logic [COUNT_W-1:0] AVG_COUNT_RST = 8'd1;
	localparam logic [GAIN_W-1:0]  GAIN_RST      = 32'h0001_0000;
	localparam logic [CORR_W-1:0]  MAP_BIAS      = 27'h07F_FFFF;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 2'd2;

	typedef logic signed [OFFSET_W-1:0] offset_t;
	typedef logic signed [CORR_W-1:0]   corr_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [UNITS_W-1:0]  units_t;
	typedef logic [COUNT_W-1:0]         count_t;
	typedef logic [GAIN_W-1:0]          gain_t;

	typedef struct packed {
		logic done;
		logic run_end;
		logic kind;
	} acc_stat_t;

endpackage

/* sv/lcsat_if.sv */
interface lcsat_sample_if import lcsat_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                func;
	logic [SAMPLE_W-1:0] sample_word;

	modport source (output valid, output func, output sample_word, input ready);
	modport sink (input valid, input func, input sample_word, output ready);
endinterface

interface lcsat_result_if import lcsat_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   run_kind;
	corr_t  average_value;
	units_t units_value;

	modport source (output valid, output run_kind, output average_value, output units_value,
		input ready);
	modport sink (input valid, input run_kind, input average_value, input units_value,
		output ready);
endinterface

interface lcsat_cfg_if import lcsat_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/load_cell_sample_average_tare_unit.sv */
// A sample that does not close a run holds the input off until it has been summed.
// A sample that closes a tare run gives its result once the 36-step serial divider is through;
// a measure run also passes through the 32-step serial multiplier.
// The input is taken again once the result sits in the output register.
// Reset clears the sum, count, mode and tare, sets average_count to 1 and gain to 1.0.
module load_cell_sample_average_tare_unit import lcsat_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	lcsat_sample_if.sink   sample_in,
	lcsat_result_if.source result_out,
	lcsat_cfg_if.sink      cfg
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_MUL,
		ST_EMIT
	} state_t;

	state_t    state_q;
	logic      out_valid_q;
	logic      out_kind_q;
	corr_t     out_avg_q;
	units_t    out_units_q;
	corr_t     avg_q;
	units_t    units_q;
	offset_t   zero_offset_q;
	count_t    average_count_q;
	gain_t     gain_q;
	corr_t     tare_q;

	acc_stat_t stat;
	sum_t      acc_sum;
	count_t    acc_count;
	logic      take;
	logic      div_start;
	logic      div_done;
	corr_t     div_quo;
	logic      mul_start;
	logic      mul_done;
	units_t    mul_units;

	assign sample_in.ready = (state_q == ST_IDLE);
	assign take            = sample_in.valid & sample_in.ready;
	assign div_start       = (state_q == ST_ACC) & stat.done & stat.run_end;
	assign mul_start       = (state_q == ST_DIV) & div_done & ~stat.kind;
	assign cfg.ready       = 1'b1;

	lcsat_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.func         (sample_in.func),
		.sample_word  (sample_in.sample_word),
		.zero_offset  (zero_offset_q),
		.tare         (tare_q),
		.average_count(average_count_q),
		.stat         (stat),
		.sum          (acc_sum),
		.count        (acc_count)
	);

	lcsat_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(acc_sum),
		.divisor (acc_count),
		.done    (div_done),
		.quotient(div_quo)
	);

	lcsat_mul u_mul (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (mul_start),
		.multiplicand(div_quo),
		.gain        (gain_q),
		.done        (mul_done),
		.units       (mul_units)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_kind_q  <= 1'b0;
			out_avg_q   <= '0;
			out_units_q <= '0;
			avg_q       <= '0;
			units_q     <= '0;
		end else begin
			if (result_out.ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (stat.done) begin
						state_q <= stat.run_end ? ST_DIV : ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						avg_q <= div_quo;
						if (stat.kind) begin
							units_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						units_q <= mul_units;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || result_out.ready) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= stat.kind;
						out_avg_q   <= avg_q;
						out_units_q <= units_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q <= '0;
		end else if ((state_q == ST_DIV) && div_done && stat.kind) begin
			tare_q <= div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q   <= '0;
			average_count_q <= AVG_COUNT_RST;
			gain_q          <= GAIN_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ZERO_OFFSET:   zero_offset_q   <= offset_t'(cfg.data[OFFSET_W-1:0]);
				REG_AVERAGE_COUNT: average_count_q <= cfg.data[COUNT_W-1:0];
				REG_GAIN:          gain_q          <= cfg.data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.run_kind      = out_kind_q;
	assign result_out.average_value = out_avg_q;
	assign result_out.units_value   = out_units_q;

endmodule

/* sv/lcsat_accum.sv */
module lcsat_accum import lcsat_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                func,
	input  logic [SAMPLE_W-1:0] sample_word,
	input  offset_t             zero_offset,
	input  corr_t               tare,
	input  count_t              average_count,
	output acc_stat_t           stat,
	output sum_t                sum,
	output count_t              count
);

	logic   step_s1;
	logic   restart_s1;
	corr_t  corr_s1;
	logic   mode_q;
	sum_t   sum_q;
	count_t cnt_q;
	logic   done_q;
	logic   end_q;

	logic [CORR_W-1:0] mapped;
	corr_t             corr_next;
	sum_t              sum_next;
	count_t            cnt_next;
	count_t            target;
	logic              run_end;

	always_comb begin
		if (sample_word[SAMPLE_W-1]) begin
			mapped = {{(CORR_W-SAMPLE_W+1){1'b0}}, sample_word[SAMPLE_W-2:0]};
		end else begin
			mapped = CORR_W'(sample_word) + MAP_BIAS;
		end
		corr_next = corr_t'(mapped) - CORR_W'(zero_offset) - (func ? corr_t'(0) : tare);
		sum_next  = (restart_s1 ? sum_t'(0) : sum_q) + SUM_W'(corr_s1);
		cnt_next  = (restart_s1 ? count_t'(0) : cnt_q) + count_t'(1);
		target    = mode_q ? TARE_COUNT : average_count;
		run_end   = (cnt_next != count_t'(0)) && (cnt_next >= target);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1    <= 1'b0;
			restart_s1 <= 1'b0;
			mode_q     <= 1'b0;
			sum_q      <= '0;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			end_q      <= 1'b0;
		end else begin
			step_s1 <= take;
			done_q  <= step_s1;
			end_q   <= step_s1 & run_end;
			if (take) begin
				mode_q     <= func;
				restart_s1 <= (func != mode_q);
			end
			if (step_s1) begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
			end else if (end_q) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			corr_s1 <= corr_next;
		end
	end

	assign stat  = '{done: done_q, run_end: end_q, kind: mode_q};
	assign sum   = sum_q;
	assign count = cnt_q;

endmodule

/* sv/lcsat_div.sv */
module lcsat_div import lcsat_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  sum_t   dividend,
	input  count_t divisor,
	output logic   done,
	output corr_t  quotient
);

	localparam int STEP_W = $clog2(DIV_STEPS);

	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [SUM_W-1:0]  dvd_q;
	count_t            dsr_q;
	count_t            rem_q;
	logic [CORR_W-1:0] quo_q;
	corr_t             quotient_q;

	logic [SUM_W-1:0]   magnitude;
	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   diff;
	logic               fits;

	always_comb begin
		magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
		trial     = {rem_q, dvd_q[SUM_W-1]};
		diff      = trial - {1'b0, dsr_q};
		fits      = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			fin_q  <= busy_q & ~start & (step_q == '0);
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= magnitude;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			rem_q <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
			quo_q <= {quo_q[CORR_W-2:0], fits};
		end
		if (fin_q) begin
			quotient_q <= neg_q ? corr_t'(-quo_q) : corr_t'(quo_q);
		end
	end

	assign done     = done_q;
	assign quotient = quotient_q;

endmodule

/* sv/lcsat_mul.sv */
module lcsat_mul import lcsat_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  corr_t  multiplicand,
	input  gain_t  gain,
	output logic   done,
	output units_t units
);

	localparam int STEP_W = $clog2(MUL_STEPS);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	corr_t             a_q;
	gain_t             g_q;
	logic [CORR_W:0]   p_q;
	logic [GAIN_W-1:0] lo_q;

	logic [CORR_W:0] addend;
	logic [CORR_W:0] psum;

	always_comb begin
		addend = g_q[0] ? {a_q[CORR_W-1], a_q} : '0;
		psum   = p_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q & ~start & (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(MUL_STEPS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= multiplicand;
			g_q  <= gain;
			p_q  <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			p_q  <= {psum[CORR_W], psum[CORR_W:1]};
			lo_q <= {psum[0], lo_q[GAIN_W-1:1]};
			g_q  <= {1'b0, g_q[GAIN_W-1:1]};
		end
	end

	assign done  = done_q;
	assign units = {p_q[CORR_W-1:0], lo_q[GAIN_W-1:FRAC_W]};

endmodule

/* sv/lcsat_chk.sv */
module lcsat_chk import lcsat_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input logic   run_kind,
	input units_t units_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped before it was taken");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transaction");

	a_tare_units_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_kind |-> units_value == '0)
		else $error("tare result carries nonzero units");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a preceding busy cycle");

endmodule

bind load_cell_sample_average_tare_unit lcsat_chk u_lcsat_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_in.valid),
	.in_ready   (sample_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.run_kind   (result_out.run_kind),
	.units_value(result_out.units_value)
);

/* dv/lcsat_average_checker.sv */
module lcsat_average_checker import lcsat_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	lcsat_sample_if sample_mon,
	lcsat_result_if result_mon,
	lcsat_cfg_if    cfg_mon,
	output int      mismatches,
	output int      pending
);

	typedef struct packed {
		logic   kind;
		corr_t  average;
		units_t units;
	} run_result_t;

	offset_t     zero_offset;
	count_t      average_count;
	gain_t       gain;
	sum_t        run_sum;
	count_t      run_samples;
	logic        run_mode;
	corr_t       tare;
	int          errors;
	run_result_t want;
	run_result_t expected_runs[$];

	task automatic accumulate_sample(input logic func, input logic [SAMPLE_W-1:0] word);
		longint      mapped;
		longint      corrected;
		longint      quotient;
		longint      product;
		longint      shifted;
		corr_t       sample;
		corr_t       average;
		count_t      target;
		run_result_t run;
		if (func != run_mode) begin
			run_mode = func;
			run_sum = '0;
			run_samples = '0;
		end
		mapped = word[SAMPLE_W-1] ? {41'd0, word[SAMPLE_W-2:0]}
			: {40'd0, word} + {37'd0, MAP_BIAS};
		corrected = mapped - zero_offset;
		if (!func) begin
			corrected = corrected - tare;
		end
		sample = corrected[CORR_W-1:0];
		run_sum = run_sum + sample;
		run_samples = run_samples + 1'b1;
		target = func ? TARE_COUNT : average_count;
		if (target == '0) begin
			target = count_t'(1);
		end
		if (run_samples != '0 && run_samples >= target) begin
			quotient = longint'(run_sum) / longint'({56'd0, run_samples});
			average = quotient[CORR_W-1:0];
			run.kind = func;
			run.average = average;
			if (func) begin
				tare = average;
				run.units = '0;
			end else begin
				product = longint'(average) * longint'({32'd0, gain});
				shifted = product >>> FRAC_W;
				run.units = shifted[UNITS_W-1:0];
			end
			expected_runs.push_back(run);
			run_sum = '0;
			run_samples = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset = '0;
			average_count = AVG_COUNT_RST;
			gain = GAIN_RST;
			run_sum = '0;
			run_samples = '0;
			run_mode = 1'b0;
			tare = '0;
			errors = 0;
			expected_runs.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_mon.index)
					REG_ZERO_OFFSET: zero_offset = cfg_mon.data[OFFSET_W-1:0];
					REG_AVERAGE_COUNT: average_count = cfg_mon.data[COUNT_W-1:0];
					REG_GAIN: gain = cfg_mon.data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (result_mon.valid && result_mon.ready) begin
				if (expected_runs.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("Unexpected result: kind %0d average %0d units %0d",
							result_mon.run_kind, result_mon.average_value,
							result_mon.units_value);
					end
				end else begin
					want = expected_runs.pop_front();
					if (result_mon.run_kind !== want.kind
						|| result_mon.average_value !== want.average
						|| result_mon.units_value !== want.units) begin
						errors++;
						if (errors <= 10) begin
							$display({"Result mismatch: expected kind %0d average %0d",
								" units %0d, got kind %0d average %0d units %0d"},
								want.kind, $signed(want.average), $signed(want.units),
								result_mon.run_kind, result_mon.average_value,
								result_mon.units_value);
						end
					end
				end
			end
			if (sample_mon.valid && sample_mon.ready) begin
				accumulate_sample(sample_mon.func, sample_mon.sample_word);
			end
			mismatches <= errors;
			pending <= expected_runs.size();
		end
	end

endmodule

/* dv/testbench.sv */
module testbench;
	import lcsat_pkg::*;

	localparam int      SAMPLE_TARGET = 1650;
	localparam int      SETTLE_CYCLES = 100;
	localparam int      LIMIT_CYCLES  = 1500000;
	localparam logic    FUNC_MEASURE  = 1'b0;
	localparam logic    FUNC_TARE     = 1'b1;
	localparam offset_t OFFSET_MAX    = {1'b0, {(OFFSET_W-1){1'b1}}};
	localparam offset_t OFFSET_MIN    = {1'b1, {(OFFSET_W-1){1'b0}}};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	int      mismatches;
	int      pending;
	int      sent = 0;
	bit      steady = 1'b0;
	offset_t cur_offset;
	count_t  cur_count;
	gain_t   cur_gain;

	lcsat_sample_if sample_bus();
	lcsat_result_if result_bus();
	lcsat_cfg_if    cfg_bus();

	load_cell_sample_average_tare_unit u_dut (
		.clk,
		.arst_n,
		.sample_in(sample_bus),
		.result_out(result_bus),
		.cfg(cfg_bus)
	);

	lcsat_average_checker u_checker (
		.clk,
		.arst_n,
		.sample_mon(sample_bus),
		.result_mon(result_bus),
		.cfg_mon(cfg_bus),
		.mismatches,
		.pending
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#(12 * LIMIT_CYCLES);
		$display("Some tests failed");
		$finish;
	end

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic logic [SAMPLE_W-1:0] draw_word();
		case ($urandom_range(0, 7))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return 24'h800000;
			3: return 24'h7FFFFF;
			default: return SAMPLE_W'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	task automatic send_sample(input logic func, input logic [SAMPLE_W-1:0] word);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.func <= func;
		sample_bus.sample_word <= word;
		do @(posedge clk); while (!(sample_bus.valid && sample_bus.ready));
		sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= index;
		cfg_bus.data <= data;
		do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
	endtask

	task automatic set_config();
		write_reg(REG_ZERO_OFFSET, {{(CFG_DATA_W-OFFSET_W){cur_offset[OFFSET_W-1]}}, cur_offset});
		write_reg(REG_AVERAGE_COUNT, {{(CFG_DATA_W-COUNT_W){1'b0}}, cur_count});
		write_reg(REG_GAIN, cur_gain);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		sample_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic draw_config();
		int pick;
		case ($urandom_range(0, 5))
			0: cur_offset = OFFSET_MAX;
			1: cur_offset = OFFSET_MIN;
			2: cur_offset = '0;
			default: cur_offset = offset_t'($urandom());
		endcase
		case ($urandom_range(0, 5))
			0: cur_gain = '0;
			1: cur_gain = '1;
			2: cur_gain = GAIN_RST;
			default: cur_gain = $urandom();
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			cur_count = count_t'($urandom_range(1, 4));
		end else if (pick < 80) begin
			cur_count = count_t'($urandom_range(5, 20));
		end else if (pick < 90) begin
			cur_count = count_t'($urandom_range(21, 254));
		end else if (pick < 95) begin
			cur_count = 8'd255;
		end else begin
			cur_count = '0;
		end
	endtask

	task automatic directed_part();
		send_sample(FUNC_MEASURE, 24'h000000);
		send_sample(FUNC_MEASURE, 24'hFFFFFF);
		send_sample(FUNC_MEASURE, 24'h800000);
		send_sample(FUNC_MEASURE, 24'h7FFFFF);
		wait_idle();
		cur_offset = OFFSET_MAX;
		cur_count = '0;
		cur_gain = '1;
		set_config();
		send_sample(FUNC_MEASURE, 24'h000000);
		send_sample(FUNC_MEASURE, 24'hFFFFFF);
		wait_idle();
		cur_offset = OFFSET_MIN;
		cur_gain = '0;
		set_config();
		send_sample(FUNC_MEASURE, 24'hFFFFFF);
		send_sample(FUNC_MEASURE, 24'h7FFFFF);
		send_sample(FUNC_MEASURE, draw_word());
		wait_idle();
		// Lowering the count below the samples already summed closes the run on the next one.
		cur_gain = 32'h0001_8000;
		cur_count = 8'd8;
		set_config();
		repeat (5) send_sample(FUNC_MEASURE, draw_word());
		wait_idle();
		cur_count = 8'd3;
		set_config();
		send_sample(FUNC_MEASURE, draw_word());
		wait_idle();
		// A change of mode drops the partial tare run and starts a fresh measure run.
		cur_count = 8'd2;
		set_config();
		send_sample(FUNC_TARE, draw_word());
		send_sample(FUNC_TARE, draw_word());
		send_sample(FUNC_MEASURE, draw_word());
		send_sample(FUNC_MEASURE, draw_word());
	endtask

	task automatic random_part();
		int pick;
		int span;
		int runs;
		while (sent < SAMPLE_TARGET) begin
			wait_idle();
			draw_config();
			set_config();
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 5)) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					repeat (TARE_COUNT) send_sample(FUNC_TARE, draw_word());
				end else if (pick < 80) begin
					span = (cur_count == '0) ? 1 : int'(cur_count);
					runs = (span > 20) ? 1 : $urandom_range(1, 4);
					repeat (span * runs) send_sample(FUNC_MEASURE, draw_word());
				end else begin
					repeat ($urandom_range(1, 12)) begin
						send_sample(logic'($urandom_range(0, 1)), draw_word());
					end
				end
			end
		end
	endtask

	initial begin
		int stall;
		result_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
		end
	end

	initial begin
		sample_bus.valid <= 1'b0;
		sample_bus.func <= FUNC_MEASURE;
		sample_bus.sample_word <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_ZERO_OFFSET;
		cfg_bus.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		directed_part();
		random_part();
		wait_idle();
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/lcsat_pkg.sv
sv/lcsat_if.sv
sv/lcsat_accum.sv
sv/lcsat_div.sv
sv/lcsat_mul.sv
sv/load_cell_sample_average_tare_unit.sv
sv/lcsat_chk.sv
dv/lcsat_average_checker.sv
dv/testbench.sv
